// ===== rtl/core/vsaa_pkg.sv =====
// Package: constants and types for the vital sign averager.
package vsaa_pkg;
  localparam int WINDOW_DEF = 600;
  localparam int PULSE_SUM_BITS_DEF = 16;
  localparam int CNT_W = 10;
  localparam int TSUM_W = 26;
  localparam int PULSE_W = 16;
  localparam int TEMP_W = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PULSE_ACCEPT_MAX = 250;
  localparam int REMOVE_PULSE_FLOOR = 30;
  localparam int REMOVE_TEMP_FLOOR = 3000;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_PREV_OK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_DROP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd7;

  // Classified sample handed from front to back.
  typedef struct packed {
    logic signed [PULSE_W-1:0] pulse;
    logic signed [TEMP_W-1:0] temp;
    logic report;
  } vsaa_item_t;

  typedef struct packed {
    logic [7:0] pulse_low_limit;
    logic [7:0] pulse_high_limit;
    logic signed [TEMP_W-1:0] temp_high_limit;
    logic signed [TEMP_W-1:0] temp_low_limit;
    logic signed [TEMP_W-1:0] temp_prev_ok_level;
    logic signed [TEMP_W-1:0] temp_drop_level;
    logic [9:0] stuck_limit;
    logic [15:0] report_period;
  } vsaa_cfg_t;
endpackage

// ===== rtl/core/vsaa_front.sv =====
// Front: stuck-pulse replacement, report tick counting and queue of items.
module vsaa_front import vsaa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  vsaa_cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [PULSE_W-1:0] pulse_sample,
  input  logic signed [TEMP_W-1:0] temp_sample,
  output logic q_valid,
  input  logic q_pop,
  output vsaa_item_t q_item
);
  vsaa_item_t q [QUEUE_DEPTH];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  logic [16:0] tick_counter;
  logic signed [PULSE_W-1:0] repeat_value;
  logic [9:0] repeat_counter;
  logic accept;
  vsaa_item_t item;
  logic [16:0] tick_inc;

  assign in_stall = (cnt == 2'(QUEUE_DEPTH));
  assign accept = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign q_item = q[rd_ptr];
  assign tick_inc = tick_counter + 17'd1;

  always_comb begin
    item.temp = temp_sample;
    item.pulse = pulse_sample;
    if (pulse_sample == repeat_value && repeat_counter > cfg.stuck_limit) begin
      item.pulse = 16'sd1;
    end
    item.report = (tick_inc > {1'b0, cfg.report_period});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      tick_counter <= '0;
      repeat_value <= '0;
      repeat_counter <= '0;
    end else begin
      if (accept) begin
        q[wr_ptr] <= item;
        wr_ptr <= ~wr_ptr;
        tick_counter <= item.report ? 17'd0 : tick_inc;
        if (pulse_sample != repeat_value) begin
          repeat_counter <= '0;
          repeat_value <= pulse_sample;
        end else if (repeat_counter <= cfg.stuck_limit && repeat_counter != 10'd1023) begin
          repeat_counter <= repeat_counter + 10'd1;
        end
      end
      if (q_pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(accept) - 2'(q_pop);
    end
  end
endmodule

// ===== rtl/core/vsaa_div.sv =====
// Shared restoring divider for window averages (non-negative operands).
module vsaa_div import vsaa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [TSUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic busy,
  output logic [TSUM_W-1:0] quotient
);
  logic [4:0] steps;
  logic [CNT_W:0] rem;
  logic [CNT_W:0] trial;
  logic [CNT_W-1:0] dvs;

  assign trial = {rem[CNT_W-1:0], quotient[TSUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy <= 1'b1;
      steps <= 5'(TSUM_W - 1);
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        quotient <= {quotient[TSUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quotient <= {quotient[TSUM_W-2:0], 1'b0};
      end
      if (steps == 5'd0) busy <= 1'b0;
      steps <= steps - 5'd1;
    end
  end
endmodule

// ===== rtl/core/vsaa_back.sv =====
// Back: window accumulation, averaging and report generation.
module vsaa_back import vsaa_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int PULSE_SUM_BITS = PULSE_SUM_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  vsaa_cfg_t cfg,
  input  logic q_valid,
  output logic q_pop,
  input  vsaa_item_t q_item,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] avg_pulse,
  output logic signed [TEMP_W-1:0] avg_temp,
  output logic removed_flag,
  output logic problem_flag
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TDIV = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_PDIV = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;
  localparam int PS_W = PULSE_SUM_BITS + 1;
  localparam logic signed [PS_W-1:0] PTOP = PS_W'((64'd1 << (PULSE_SUM_BITS - 1)) - 64'd1);

  logic [2:0] state;
  logic rep_pend, pdiv_pend;
  logic [CNT_W-1:0] temp_count, pulse_count;
  logic signed [TSUM_W-1:0] temp_sum;
  logic signed [PULSE_SUM_BITS-1:0] pulse_sum;
  logic [7:0] pulse_average, prev_pulse;
  logic signed [TEMP_W-1:0] temp_average, prev_temp;
  logic removed_latch;
  logic tneg, pclose;
  logic div_start, div_busy;
  logic [TSUM_W-1:0] div_a, div_q;
  logic [CNT_W-1:0] div_b;
  logic [CNT_W-1:0] tc_next;
  logic signed [TSUM_W-1:0] ts_next;
  logic signed [PS_W-1:0] psum_ext, pt;
  logic p_ok;
  logic removed, p_bad, t_bad;
  logic signed [8:0] p9, prev9, low9, high9;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign tc_next = temp_count + CNT_W'(1);
  assign ts_next = temp_sum + TSUM_W'(q_item.temp);
  assign psum_ext = PS_W'(pulse_sum);
  assign pt = psum_ext + PS_W'(q_item.pulse);
  assign pclose = (pulse_sum > 0 && (pt < 0 || pt > PTOP)) || (pulse_count > CNT_W'(WINDOW));
  assign p_ok = q_item.pulse > 0 && q_item.pulse < PS_W'(PULSE_ACCEPT_MAX);

  assign p9 = {1'b0, pulse_average};
  assign prev9 = {1'b0, prev_pulse};
  assign low9 = {1'b0, cfg.pulse_low_limit};
  assign high9 = {1'b0, cfg.pulse_high_limit};
  always_comb begin
    removed = removed_latch
      || (p9 < low9 && temp_average < cfg.temp_drop_level && prev9 >= low9
          && prev_temp >= cfg.temp_prev_ok_level)
      || (p9 < 9'(REMOVE_PULSE_FLOOR) && temp_average < TEMP_W'(REMOVE_TEMP_FLOOR));
    p_bad = p9 >= high9 || p9 < low9;
    t_bad = temp_average >= cfg.temp_high_limit || temp_average < cfg.temp_low_limit;
  end

  vsaa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  always_comb begin
    div_start = 1'b0;
    div_a = (ts_next < 0) ? TSUM_W'(-ts_next) : TSUM_W'(ts_next);
    div_b = tc_next;
    if (state == S_PSTART && pdiv_pend) begin
      div_start = 1'b1;
      div_a = TSUM_W'($unsigned(pulse_sum));
      div_b = pulse_count;
    end else if (state == S_IDLE && q_valid && tc_next > CNT_W'(WINDOW)) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rep_pend <= 1'b0;
      pdiv_pend <= 1'b0;
      temp_count <= '0;
      temp_sum <= '0;
      pulse_count <= '0;
      pulse_sum <= '0;
      pulse_average <= '0;
      temp_average <= '0;
      prev_pulse <= '0;
      prev_temp <= '0;
      removed_latch <= 1'b0;
      tneg <= 1'b0;
    end else begin
      if (state == S_REPORT && rep_pend && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            tneg <= ts_next < 0;
            if (tc_next > CNT_W'(WINDOW)) begin
              temp_count <= '0;
              temp_sum <= '0;
              state <= S_TDIV;
            end else begin
              temp_count <= tc_next;
              temp_sum <= ts_next;
              state <= S_PSTART;
            end
            if (!pclose && p_ok) begin
              pulse_count <= pulse_count + CNT_W'(1);
              pulse_sum <= PULSE_SUM_BITS'(pt);
            end
            rep_pend <= q_item.report;
            pdiv_pend <= pclose && pulse_count != '0;
          end
        end
        S_TDIV: begin
          if (!div_start && !div_busy) begin
            temp_average <= tneg ? TEMP_W'(-div_q) : TEMP_W'(div_q);
            state <= S_PSTART;
          end
        end
        S_PSTART: begin
          if (pdiv_pend) begin
            state <= S_PDIV;
          end else begin
            state <= S_REPORT;
          end
        end
        S_PDIV: begin
          if (!div_busy) begin
            pulse_average <= div_q[7:0];
            pulse_count <= '0;
            pulse_sum <= '0;
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (!rep_pend) begin
            state <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            avg_pulse <= pulse_average;
            avg_temp <= temp_average;
            removed_flag <= removed;
            problem_flag <= p_bad != t_bad;
            prev_pulse <= pulse_average;
            prev_temp <= temp_average;
            removed_latch <= removed;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/vital_sign_averager_alarm.sv =====
// Top level: vital sign averager with removal and problem flags.
// Flow: each sample passes S_IDLE, S_PSTART and S_REPORT, adding S_TDIV and S_PDIV when
// the temperature or pulse window closes (26-step divider per average).
// The back end takes a new sample only once it has finished the last one; a two-entry
// queue decouples intake, and a stalled report beat holds the back end.
// Reset: synchronous active-high rst clears counters, sums, averages and the removal
// latch; limits return to their defaults.
module vital_sign_averager_alarm import vsaa_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int PULSE_SUM_BITS = PULSE_SUM_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [PULSE_W-1:0] pulse_sample,
  input  logic signed [TEMP_W-1:0] temp_sample,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] avg_pulse,
  output logic signed [TEMP_W-1:0] avg_temp,
  output logic removed_flag,
  output logic problem_flag,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  vsaa_cfg_t cfg;
  logic q_valid, q_pop;
  vsaa_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_low_limit <= 8'd50;
      cfg.pulse_high_limit <= 8'd90;
      cfg.temp_high_limit <= 15'sd3800;
      cfg.temp_low_limit <= 15'sd3600;
      cfg.temp_prev_ok_level <= 15'sd3500;
      cfg.temp_drop_level <= 15'sd3300;
      cfg.stuck_limit <= 10'd200;
      cfg.report_period <= 16'd2000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PULSE_LOW: cfg.pulse_low_limit <= cfg_data[7:0];
        REG_PULSE_HIGH: cfg.pulse_high_limit <= cfg_data[7:0];
        REG_TEMP_HIGH: cfg.temp_high_limit <= cfg_data[TEMP_W-1:0];
        REG_TEMP_LOW: cfg.temp_low_limit <= cfg_data[TEMP_W-1:0];
        REG_TEMP_PREV_OK: cfg.temp_prev_ok_level <= cfg_data[TEMP_W-1:0];
        REG_TEMP_DROP: cfg.temp_drop_level <= cfg_data[TEMP_W-1:0];
        REG_STUCK: cfg.stuck_limit <= cfg_data[9:0];
        REG_PERIOD: cfg.report_period <= cfg_data;
        default: ;
      endcase
    end
  end

  vsaa_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(in_valid), .in_stall(in_stall),
    .pulse_sample(pulse_sample), .temp_sample(temp_sample),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  vsaa_back #(.WINDOW(WINDOW), .PULSE_SUM_BITS(PULSE_SUM_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .avg_pulse(avg_pulse),
    .avg_temp(avg_temp), .removed_flag(removed_flag), .problem_flag(problem_flag)
  );
endmodule

// ===== rtl/core/vsaa_checker.sv =====
// Checker: port-level properties of the vital sign averager.
module vsaa_checker import vsaa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic removed_flag,
  input logic [7:0] avg_pulse
);
  logic removed_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      removed_seen <= 1'b0;
    end else if (out_valid && !out_stall && removed_flag) begin
      removed_seen <= 1'b1;
    end
  end

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("beat valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(avg_pulse) && $stable(removed_flag))
    else $error("held beat changed");
  a_latch: assert property (@(posedge clk) disable iff (rst)
    out_valid && removed_seen |-> removed_flag) else $error("removal flag not latched");
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> avg_pulse < 8'd250) else $error("pulse average out of range");
endmodule

bind vital_sign_averager_alarm vsaa_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .removed_flag(removed_flag), .avg_pulse(avg_pulse)
);

// ===== sim/testbench.sv =====
// Testbench for vital_sign_averager_alarm: random traffic, config phases, report checking.
`timescale 1ns / 1ps
module testbench;
  import vsaa_pkg::*;

  typedef struct {
    logic signed [PULSE_W-1:0] pulse;
    logic signed [TEMP_W-1:0] temp;
  } sample_t;

  typedef struct {
    logic [7:0] avg_pulse;
    logic signed [TEMP_W-1:0] avg_temp;
    logic removed;
    logic problem;
  } report_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [PULSE_W-1:0] pulse_sample = '0;
  logic signed [TEMP_W-1:0] temp_sample = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] avg_pulse;
  logic signed [TEMP_W-1:0] avg_temp;
  logic removed_flag;
  logic problem_flag;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vital_sign_averager_alarm DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  sample_t pending[$];
  report_t reports_due[$];
  bit quiet = 0;
  bit hold_go = 0;
  bit in_took = 0;
  bit failed = 0;
  int in_gap = 0;
  int rx_wait = 0;
  int hold_cnt = 0;
  longint cycles = 0;

  // predictor state and settings
  longint lim_pulse_low, lim_pulse_high, lim_temp_high, lim_temp_low;
  longint lim_prev_ok, lim_drop, stuck_lim, period;
  longint ticks, rep_val, rep_cnt, p_count, p_sum, p_avg;
  longint t_count, t_sum, t_avg, last_pulse, last_temp;
  bit removed_hold;

  task automatic reset_predictor();
    lim_pulse_low = 50; lim_pulse_high = 90; lim_temp_high = 3800; lim_temp_low = 3600;
    lim_prev_ok = 3500; lim_drop = 3300; stuck_lim = 200; period = 2000;
    ticks = 0; rep_val = 0; rep_cnt = 0; p_count = 0; p_sum = 0; p_avg = 0;
    t_count = 0; t_sum = 0; t_avg = 0; last_pulse = 0; last_temp = 0; removed_hold = 0;
  endtask

  task automatic apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    logic signed [TEMP_W-1:0] s;
    s = v[TEMP_W-1:0];
    case (idx)
      REG_PULSE_LOW: lim_pulse_low = v[7:0];
      REG_PULSE_HIGH: lim_pulse_high = v[7:0];
      REG_TEMP_HIGH: lim_temp_high = s;
      REG_TEMP_LOW: lim_temp_low = s;
      REG_TEMP_PREV_OK: lim_prev_ok = s;
      REG_TEMP_DROP: lim_drop = s;
      REG_STUCK: stuck_lim = v[9:0];
      REG_PERIOD: period = v;
      default: ;
    endcase
  endtask

  task automatic add_pulse(longint x);
    longint t;
    bit ovf;
    t = p_sum + x;
    ovf = p_sum > 0 && (t < 0 || t > 32767);
    if (ovf || p_count > WINDOW_DEF) begin
      if (p_count != 0) p_avg = p_sum / p_count;
      p_count = 0;
      p_sum = 0;
    end else if (x > 0 && x < PULSE_ACCEPT_MAX) begin
      p_count++;
      p_sum = t;
    end
  endtask

  task automatic predict_tick(sample_t s);
    longint ps, ts;
    bit rm, pbad, tbad;
    report_t r;
    ps = s.pulse;
    ts = s.temp;
    t_count++;
    t_sum += ts;
    if (t_count > WINDOW_DEF) begin
      t_avg = t_sum / t_count;
      t_count = 0;
      t_sum = 0;
    end
    if (ps == rep_val) begin
      if (rep_cnt > stuck_lim) add_pulse(1);
      else begin
        if (rep_cnt < 1023) rep_cnt++;
        add_pulse(ps);
      end
    end else begin
      rep_cnt = 0;
      rep_val = ps;
      add_pulse(ps);
    end
    ticks++;
    if (ticks > period) begin
      ticks = 0;
      rm = removed_hold ||
           (p_avg < lim_pulse_low && t_avg < lim_drop &&
            last_pulse >= lim_pulse_low && last_temp >= lim_prev_ok) ||
           (p_avg < REMOVE_PULSE_FLOOR && t_avg < REMOVE_TEMP_FLOOR);
      last_pulse = p_avg;
      last_temp = t_avg;
      removed_hold = rm;
      pbad = p_avg >= lim_pulse_high || p_avg < lim_pulse_low;
      tbad = t_avg >= lim_temp_high || t_avg < lim_temp_low;
      r.avg_pulse = p_avg[7:0];
      r.avg_temp = t_avg[TEMP_W-1:0];
      r.removed = rm;
      r.problem = pbad != tbad;
      reports_due.push_back(r);
    end
  endtask

  // input beat driver
  always @(negedge clk) begin
    sample_t s;
    if (!rst) begin
      if (in_valid && !in_took) begin
      end else if (in_gap > 0) begin
        in_valid <= 0;
        in_gap--;
      end else if (pending.size() > 0) begin
        s = pending.pop_front();
        pulse_sample <= s.pulse;
        temp_sample <= s.temp;
        in_valid <= 1;
        in_gap = quiet ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall driver
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1;
      hold_cnt--;
    end else if (hold_go) begin
      hold_go = 0;
      hold_cnt = 400;
      out_stall <= 1;
    end else if (rx_wait > 0) begin
      out_stall <= 1;
      rx_wait--;
    end else begin
      out_stall <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    sample_t s;
    report_t e;
    cycles++;
    if (cycles > 3000000) begin
      $display("vital_sign_averager_alarm verification failed");
      $finish;
    end
    in_took = in_valid && !in_stall && !rst;
    if (in_took) begin
      s.pulse = pulse_sample;
      s.temp = temp_sample;
      predict_tick(s);
    end
    if (!rst && out_valid && !out_stall) begin
      rx_wait = quiet ? 0 : $urandom_range(0, 9);
      if (reports_due.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected report beat", $time);
      end else begin
        e = reports_due.pop_front();
        if (avg_pulse !== e.avg_pulse) begin
          failed = 1;
          $display("%0t: avg_pulse exp %0d got %0d", $time, e.avg_pulse, avg_pulse);
        end
        if (avg_temp !== e.avg_temp) begin
          failed = 1;
          $display("%0t: avg_temp exp %0d got %0d", $time, e.avg_temp, avg_temp);
        end
        if (removed_flag !== e.removed) begin
          failed = 1;
          $display("%0t: removed_flag exp %0b got %0b", $time, e.removed, removed_flag);
        end
        if (problem_flag !== e.problem) begin
          failed = 1;
          $display("%0t: problem_flag exp %0b got %0b", $time, e.problem, problem_flag);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic write_all(int pl, int ph, int th, int tl, int tp, int td, int st, int per);
    write_reg(REG_PULSE_LOW, CFG_DATA_W'(pl));
    write_reg(REG_PULSE_HIGH, CFG_DATA_W'(ph));
    write_reg(REG_TEMP_HIGH, CFG_DATA_W'(th));
    write_reg(REG_TEMP_LOW, CFG_DATA_W'(tl));
    write_reg(REG_TEMP_PREV_OK, CFG_DATA_W'(tp));
    write_reg(REG_TEMP_DROP, CFG_DATA_W'(td));
    write_reg(REG_STUCK, CFG_DATA_W'(st));
    write_reg(REG_PERIOD, CFG_DATA_W'(per));
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending.size() > 0 || in_valid || reports_due.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push(int p, int t);
    sample_t s;
    s.pulse = PULSE_W'(p);
    s.temp = TEMP_W'(t);
    pending.push_back(s);
  endtask

  task automatic random_samples(int n);
    int p, t, run;
    p = 70;
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (run > 0) run--;
      else begin
        case ($urandom_range(0, 19))
          0: p = $signed(16'($urandom));
          1: p = -$urandom_range(1, 300);
          2: p = $urandom_range(250, 400);
          3: p = 0;
          4: begin
            run = $urandom_range(2, 30);
          end
          5, 6, 7: p = $urandom_range(10, 60);
          default: p = $urandom_range(1, 249);
        endcase
      end
      t = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16500) - 4000
                                        : $urandom_range(2800, 4000);
      push(p, t);
    end
  endtask

  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, stuck replacement, negative and out of range pulses
    write_all(50, 90, 3800, 3600, 3500, 3300, 2, 0);
    push(-32768, -4000); push(32767, 12500); push(0, 0); push(250, 3700);
    push(249, 3700); push(1, 3700); push(-1, 3700); push(100, 3000);
    for (int i = 0; i < 6; i++) push(77, 3650);
    push(200, 12500); push(-200, -4000); push(16384, 16383 - 4000);
    push(-16385, 100); push(255, 2999); push(20000, 4000); push(-5, 2000);
    push(60, 3600); push(60, 3599);
    wait_drained();

    // floors
    write_all(0, 0, -4000, -4000, -4000, -4000, 0, 1);
    random_samples(300);
    wait_drained();

    // ceilings, reports effectively off
    write_all(255, 255, 12500, 12500, 12500, 12500, 1023, 65535);
    random_samples(60);
    wait_drained();

    // every sample reports; long receiver hold-off backs up the block
    write_all(50, 90, 3800, 3600, 3500, 3300, 200, 0);
    hold_go = 1;
    random_samples(400);
    wait_drained();

    quiet = 1;
    write_all(40, 100, 3900, 3500, 3400, 3200, 5, 3);
    random_samples(300);
    wait_drained();
    quiet = 0;

    for (int ph = 0; ph < 3; ph++) begin
      write_all($urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 16500) - 4000, $urandom_range(0, 16500) - 4000,
                $urandom_range(0, 16500) - 4000, $urandom_range(0, 16500) - 4000,
                $urandom_range(0, 1023), $urandom_range(0, 6));
      random_samples(300);
      wait_drained();
    end

    if (!failed) $display("vital_sign_averager_alarm verification clean");
    else $display("vital_sign_averager_alarm verification failed");
    $finish;
  end
endmodule
